>>> sv/pcmtg_pkg.sv
package pcmtg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FIELD_W  = 16;
   localparam int RATE_W   = 17;
   localparam int MS_W     = 16;
   localparam int FREQ_W   = 16;
   localparam int PROD_W   = RATE_W + MS_W;
   localparam int DIV_W    = 17;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_TONE  = 2'd1;
   localparam logic [1:0] CMD_DRAIN = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NOT_INIT = 2'd1;
   localparam logic [1:0] STS_BAD_FREQ = 2'd2;
   localparam logic [1:0] STS_OVERFLOW = 2'd3;

   localparam logic [1:0] CFG_ENABLED = 2'd0;
   localparam logic [1:0] CFG_RATE    = 2'd1;
   localparam logic [1:0] CFG_MAX_MS  = 2'd2;

   localparam logic [RATE_W-1:0]   RATE_RESET   = 17'd22050;
   localparam logic [MS_W-1:0]     MAX_MS_RESET = 16'd1000;
   localparam int                  MS_PER_S     = 1000;
   localparam logic [SAMPLE_W-1:0] TONE_HIGH    = 16'h3FFF;
   localparam logic [SAMPLE_W-1:0] TONE_LOW     = 16'hC001;

   typedef struct packed {
      logic                push;
      logic                pop;
      logic                flush;
      logic [SAMPLE_W-1:0] push_data;
   } ring_ctl_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [SAMPLE_W-1:0] left;
      logic                frame_valid;
      logic [FIELD_W-1:0]  fill;
      logic [FIELD_W-1:0]  written;
   } rsp_type;

endpackage

>>> sv/pcmtg_div.sv
module pcmtg_div
   import pcmtg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         step_in = STEP_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         done_in = step_ff == STEP_W'(1);
         rem_in  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/pcmtg_ring.sv
module pcmtg_ring
   import pcmtg_pkg::*;
#(
   parameter int DEPTH = 32768
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ring_ctl_type                 ctl,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic [SAMPLE_W-1:0]          rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= ctl.push_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign count   = count_ff;
   assign rd_data = rd_data_ff;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> count_ff != CNT_W'(DEPTH))
      else $error("push into full ring");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> count_ff != '0)
      else $error("pop from empty ring");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl.push, ctl.pop, ctl.flush}) <= 1)
      else $error("more than one ring operation in a cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not follow push");

endmodule

>>> sv/pcm_ring_fifo_tone_generator.sv
// PCM ring FIFO with square-wave tone generator.
// Requests (req_*) carry a command: write one sample, play a tone, drain one
// frame, or stop and flush. Each request yields exactly one response (rsp_*),
// in order, over a valid/ready transfer. Configuration (csr_*) is written at
// any clock edge with csr_we high; index 0 enable, 1 sample rate, 2 max tone ms.
// A write, a stop and a drain of an empty ring finish in the idle state; a drain
// of a queued sample reads the ring memory and finishes in the drain state.
// A tone waits for the serial divider to compute the half period, then makes
// one ring write per cycle until its sample count is reached or the ring is full,
// and ends with a final step. No request is taken while a drain or tone runs.
// Each response passes the holding register and then the output register.
// A finished response waits in a holding register, so one more request is
// taken while the receiver stalls; after that req_ready drops until the
// output register is freed.
// Reset clears pointers, fill count and pending responses and restores the
// configuration defaults; the sample memory is not cleared.
module pcm_ring_fifo_tone_generator
   import pcmtg_pkg::*;
#(
   parameter int RING_DEPTH = 32768
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [FREQ_W-1:0]          req_tone_freq_hz,
   input  logic [MS_W-1:0]            req_tone_duration_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic signed [SAMPLE_W-1:0] rsp_left_sample,
   output logic signed [SAMPLE_W-1:0] rsp_right_sample,
   output logic                       rsp_frame_valid,
   output logic [FIELD_W-1:0]         rsp_fill_level,
   output logic [FIELD_W-1:0]         rsp_samples_written,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [RATE_W-1:0]          csr_wdata
);

   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int ACC_W = $clog2((RING_DEPTH + 1) * MS_PER_S + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DRAIN = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_TONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              enabled_ff;
   logic [RATE_W-1:0] rate_ff;
   logic [MS_W-1:0]   max_ms_ff;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  written_ff, written_in;
   logic [DIV_W-1:0]  phase_ff, phase_in;
   logic [DIV_W-1:0]  half_ff, half_in;
   logic              sign_ff, sign_in;

   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              out_valid_ff;
   rsp_type           out_ff;

   ring_ctl_type      ring_ctl;
   logic [CNT_W-1:0]  count;
   logic [SAMPLE_W-1:0] rd_data;
   logic              full, empty;

   logic              div_start, div_done;
   logic [DIV_W-1:0]  quotient;

   logic              pend_move, req_fire, set_pend;
   logic [MS_W-1:0]   ms_clamp;
   logic [CNT_W-1:0]  cnt_res, wr_res;
   logic [CNT_W+FIELD_W-1:0] cnt_ext, wr_ext;
   rsp_type           res;

   pcmtg_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .count   (count),
      .rd_data (rd_data)
   );

   pcmtg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rate_ff),
      .divisor  ({req_tone_freq_hz, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   assign full      = count == CNT_W'(RING_DEPTH);
   assign empty     = count == '0;
   assign pend_move = pend_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) && (!pend_valid_ff || pend_move);
   assign req_fire  = req_valid && req_ready;
   assign ms_clamp  = (req_tone_duration_ms > max_ms_ff) ? max_ms_ff : req_tone_duration_ms;
   assign cnt_ext   = {{FIELD_W{1'b0}}, cnt_res};
   assign wr_ext    = {{FIELD_W{1'b0}}, wr_res};

   always_comb begin
      state_in      = state_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      written_in    = written_ff;
      phase_in      = phase_ff;
      half_in       = half_ff;
      sign_in       = sign_ff;
      ring_ctl      = '0;
      div_start     = 1'b0;
      set_pend      = 1'b0;
      cnt_res       = count;
      wr_res        = '0;
      res.status      = STS_OK;
      res.left        = '0;
      res.frame_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_WRITE: begin
                     set_pend = 1'b1;
                     if (!enabled_ff) begin
                        res.status = STS_NOT_INIT;
                     end else if (full) begin
                        res.status = STS_OVERFLOW;
                     end else begin
                        ring_ctl.push      = 1'b1;
                        ring_ctl.push_data = $unsigned(req_sample);
                        cnt_res            = count + 1'b1;
                        wr_res             = CNT_W'(1);
                     end
                  end
                  CMD_TONE: begin
                     if (!enabled_ff) begin
                        set_pend   = 1'b1;
                        res.status = STS_NOT_INIT;
                     end else if (req_tone_freq_hz == '0) begin
                        set_pend   = 1'b1;
                        res.status = STS_BAD_FREQ;
                     end else begin
                        div_start  = 1'b1;
                        prod_in    = rate_ff * ms_clamp;
                        acc_in     = ACC_W'(MS_PER_S);
                        written_in = '0;
                        phase_in   = '0;
                        sign_in    = 1'b0;
                        state_in   = S_DIV;
                     end
                  end
                  CMD_DRAIN: begin
                     if (empty) begin
                        set_pend = 1'b1;
                     end else begin
                        ring_ctl.pop = 1'b1;
                        state_in     = S_DRAIN;
                     end
                  end
                  CMD_STOP: begin
                     set_pend       = 1'b1;
                     ring_ctl.flush = 1'b1;
                     cnt_res        = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAIN: begin
            set_pend        = 1'b1;
            res.left        = rd_data;
            res.frame_valid = 1'b1;
            state_in        = S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               half_in  = (quotient == '0) ? DIV_W'(1) : quotient;
               state_in = S_TONE;
            end
         end
         S_TONE: begin
            if (({{(PROD_W-ACC_W){1'b0}}, acc_ff} <= prod_ff) && !full) begin
               ring_ctl.push      = 1'b1;
               ring_ctl.push_data = sign_ff ? TONE_HIGH : TONE_LOW;
               acc_in             = acc_ff + ACC_W'(MS_PER_S);
               written_in         = written_ff + 1'b1;
               if (phase_ff == half_ff - 1'b1) begin
                  phase_in = '0;
                  sign_in  = !sign_ff;
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end else begin
               set_pend = 1'b1;
               wr_res   = written_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.fill    = cnt_ext[FIELD_W-1:0];
      res.written = wr_ext[FIELD_W-1:0];

      pend_valid_in = (pend_valid_ff && !pend_move) || set_pend;
      pend_in       = set_pend ? res : pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         enabled_ff    <= 1'b0;
         rate_ff       <= RATE_RESET;
         max_ms_ff     <= MAX_MS_RESET;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (pend_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CFG_ENABLED: enabled_ff <= csr_wdata[0];
               CFG_RATE:    rate_ff    <= csr_wdata;
               CFG_MAX_MS:  max_ms_ff  <= csr_wdata[MS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      written_ff <= written_in;
      phase_ff   <= phase_in;
      half_ff    <= half_in;
      sign_ff    <= sign_in;
      pend_ff    <= pend_in;
      if (pend_move) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_left_sample     = $signed(out_ff.left);
   assign rsp_right_sample    = $signed(out_ff.left);
   assign rsp_frame_valid     = out_ff.frame_valid;
   assign rsp_fill_level      = out_ff.fill;
   assign rsp_samples_written = out_ff.written;

   a_busy_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !pend_valid_ff)
      else $error("pending response while an item is in progress");

   a_drain_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> $past(ring_ctl.pop))
      else $error("drain wait without a ring read");

   a_pend_to_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("pending response not moved to free output");

endmodule
